/* hw/rtl/ped_pkg.sv */
`default_nettype none

package ped_pkg;

    // default sizes of the top level
    localparam int NUM_TASKS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DATA_WIDTH_DEF  = 32;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 3;
    localparam int ID_W       = 8;
    localparam int PRIO_W     = 3;
    localparam int KIND_W     = 2;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // opcodes of an input item
    localparam logic [OP_W-1:0] OP_POST_TASK = 2'd0;
    localparam logic [OP_W-1:0] OP_POST_ID   = 2'd1;
    localparam logic [OP_W-1:0] OP_SCHEDULE  = 2'd2;

    // kinds of a result item
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUEUED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TASK_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_PRIO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TASK_IDS    = 2'd2;

    // priority that bypasses the queue
    localparam logic [PRIO_W-1:0] PRIO_VERY_HIGH = 3'd7;

endpackage

`default_nettype wire

/* hw/rtl/priority_event_dispatcher.sv */
// channel   | valid        | stall        | payload
// ----------+--------------+--------------+------------------------------------------
// input     | i_in_valid   | o_in_stall   | i_opcode i_task_index i_event_id i_event_data
// result    | o_out_valid  | i_out_stall  | o_kind o_out_task o_out_data o_executed o_last
// config    | i_cfg_we     | -            | i_cfg_index i_cfg_data
//
// an item is taken in S_IDLE and no new item is taken until the sequencer is back there;
// a post gives one result per target slot, and a schedule pops each word in S_SCHED
// and hands it out in S_READ after the registered store read, then ends with the done item
// reset is synchronous: queues empty, event store contents left as they are
// a stalled result holds in the output register and the sequencer waits on it

`default_nettype none

module priority_event_dispatcher import ped_pkg::*; #(
    parameter int NUM_TASKS   = NUM_TASKS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input items
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OP_W-1:0]       i_opcode,
    input  wire logic [IDX_W-1:0]      i_task_index,
    input  wire logic [ID_W-1:0]       i_event_id,
    input  wire logic [OUT_DATA_W-1:0] i_event_data,
    // result items
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [KIND_W-1:0]     o_kind,
    output logic      [IDX_W-1:0]      o_out_task,
    output logic      [OUT_DATA_W-1:0] o_out_data,
    output logic                       o_executed,
    output logic                       o_last,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = NUM_TASKS * QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TIW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REJECT,
        S_POST,
        S_SCHED,
        S_READ
    } t_state;

    t_state                       r_state;
    logic [NUM_TASKS-1:0]         r_enable;
    logic [NUM_TASKS*PRIO_W-1:0]  r_prio;
    logic [NUM_TASKS*ID_W-1:0]    r_ids;
    logic [HW-1:0]                r_head  [NUM_TASKS];
    logic [CW-1:0]                r_count [NUM_TASKS];
    logic [NUM_TASKS-1:0]         r_mask;
    logic [DATA_WIDTH-1:0]        r_data;
    logic [IDX_W-1:0]             r_rej_task;
    logic [TIW-1:0]               r_rd_task;
    logic                         r_exec;

    logic                         r_out_valid;
    logic [KIND_W-1:0]            r_kind;
    logic [IDX_W-1:0]             r_task;
    logic [OUT_DATA_W-1:0]        r_out_data;
    logic                         r_executed;
    logic                         r_last;

    logic                         w_out_free;
    logic                         w_out_load;
    logic [NUM_TASKS-1:0]         w_ready_mask;
    logic [NUM_TASKS-1:0]         w_id_match;
    logic [NUM_TASKS-1:0]         w_pick_mask;
    logic [NUM_TASKS-1:0]         w_mask_rest;
    logic                         w_found;
    logic [TIW-1:0]               w_sel;
    logic [PRIO_W-1:0]            w_sel_prio;
    logic [HW-1:0]                w_sel_head;
    logic [CW-1:0]                w_sel_count;
    logic                         w_sel_full;
    logic [CW:0]                  w_sum;
    logic [HW-1:0]                w_pos;
    logic [AW-1:0]                w_base;
    logic [AW-1:0]                w_waddr;
    logic [AW-1:0]                w_raddr;
    logic                         w_mem_we;
    logic                         w_mem_re;
    logic [DATA_WIDTH-1:0]        w_rdata;
    logic                         w_idx_ok;
    logic [NUM_TASKS-1:0]         w_new_enable;

    // handshake helpers
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // a new result enters the output register this cycle
    assign w_out_load = w_out_free && ((r_state == S_REJECT) || (r_state == S_POST)
                        || (r_state == S_READ) || ((r_state == S_SCHED) && !w_found));

    // per-slot flags
    always_comb begin
        for (int t = 0; t < NUM_TASKS; t++) begin
            w_ready_mask[t] = r_enable[t] && (r_count[t] != '0);
            w_id_match[t]   = r_enable[t] && (r_ids[t*ID_W +: ID_W] == i_event_id);
        end
    end

    assign w_idx_ok = ({1'b0, i_task_index} < (IDX_W + 1)'(NUM_TASKS))
                      && r_enable[i_task_index[TIW-1:0]];

    // next slot in dispatch order
    assign w_pick_mask = (r_state == S_POST) ? r_mask : w_ready_mask;

    ped_pick #(
        .NUM_TASKS (NUM_TASKS),
        .TIW       (TIW)
    ) u_pick (
        .i_mask  (w_pick_mask),
        .i_prio  (r_prio),
        .o_found (w_found),
        .o_sel   (w_sel)
    );

    assign w_sel_prio  = r_prio[w_sel*PRIO_W +: PRIO_W];
    assign w_sel_head  = r_head[w_sel];
    assign w_sel_count = r_count[w_sel];
    assign w_sel_full  = (w_sel_count >= CW'(QUEUE_DEPTH));
    assign w_mask_rest = r_mask & ~(NUM_TASKS'(1) << w_sel);

    // tail position wraps once at most
    assign w_sum   = (CW + 1)'(w_sel_head) + (CW + 1)'(w_sel_count);
    assign w_pos   = (w_sum >= (CW + 1)'(QUEUE_DEPTH)) ? HW'(w_sum - (CW + 1)'(QUEUE_DEPTH))
                                                       : HW'(w_sum);
    assign w_base  = AW'(w_sel) * AW'(QUEUE_DEPTH);
    assign w_waddr = w_base + AW'(w_pos);
    assign w_raddr = w_base + AW'(w_sel_head);

    // the sequencer never writes and reads the store in one phase
    assign w_mem_we = (r_state == S_POST) && w_out_free && w_found
                      && (w_sel_prio != PRIO_VERY_HIGH) && !w_sel_full;
    assign w_mem_re = (r_state == S_SCHED) && w_found;

    ped_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (r_data),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_new_enable = i_cfg_data[NUM_TASKS-1:0];

    // sequencer, queue pointers, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_enable    <= '0;
            r_prio      <= '0;
            r_ids       <= '0;
            r_exec      <= 1'b0;
            for (int t = 0; t < NUM_TASKS; t++) begin
                r_head[t]  <= '0;
                r_count[t] <= '0;
            end
        end else begin
            // output register: load a new result or let the taken one go
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // register writes; a slot that becomes enabled starts empty
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TASK_ENABLE: begin
                        for (int t = 0; t < NUM_TASKS; t++) begin
                            if (w_new_enable[t] && !r_enable[t]) begin
                                r_head[t]  <= '0;
                                r_count[t] <= '0;
                            end
                        end
                        r_enable <= w_new_enable;
                    end
                    REG_TASK_PRIO: begin
                        r_prio <= i_cfg_data[NUM_TASKS*PRIO_W-1:0];
                    end
                    REG_TASK_IDS: begin
                        r_ids <= i_cfg_data[NUM_TASKS*ID_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_data <= i_event_data[DATA_WIDTH-1:0];
                        case (i_opcode)
                            OP_POST_TASK: begin
                                if (w_idx_ok) begin
                                    r_mask  <= NUM_TASKS'(1) << i_task_index[TIW-1:0];
                                    r_state <= S_POST;
                                end else begin
                                    r_rej_task <= i_task_index;
                                    r_state    <= S_REJECT;
                                end
                            end
                            OP_POST_ID: begin
                                if (w_id_match != '0) begin
                                    r_mask  <= w_id_match;
                                    r_state <= S_POST;
                                end
                            end
                            OP_SCHEDULE: begin
                                r_exec  <= 1'b0;
                                r_state <= S_SCHED;
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                // post to a disabled or absent slot
                S_REJECT: begin
                    if (w_out_free) begin
                        r_kind      <= KIND_REJECT;
                        r_task      <= r_rej_task;
                        r_out_data  <= '0;
                        r_executed  <= 1'b0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                // one target slot per cycle while the output register is free, dispatched, queued or full
                S_POST: begin
                    if (w_out_free) begin
                        r_task      <= IDX_W'(w_sel);
                        r_executed  <= 1'b0;
                        r_last      <= (w_mask_rest == '0);
                        r_mask      <= w_mask_rest;
                        if (w_sel_prio == PRIO_VERY_HIGH) begin
                            r_kind     <= KIND_DISPATCH;
                            r_out_data <= OUT_DATA_W'(r_data);
                        end else if (w_sel_full) begin
                            r_kind     <= KIND_REJECT;
                            r_out_data <= '0;
                        end else begin
                            r_kind         <= KIND_QUEUED;
                            r_out_data     <= '0;
                            r_count[w_sel] <= w_sel_count + CW'(1);
                        end
                        if (w_mask_rest == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                // pop the head of the best non-empty queue, or finish
                S_SCHED: begin
                    if (w_found) begin
                        r_head[w_sel]  <= (w_sel_head == HW'(QUEUE_DEPTH - 1))
                                          ? '0 : w_sel_head + HW'(1);
                        r_count[w_sel] <= w_sel_count - CW'(1);
                        r_rd_task      <= w_sel;
                        r_state        <= S_READ;
                    end else if (w_out_free) begin
                        r_kind      <= KIND_DONE;
                        r_task      <= '0;
                        r_out_data  <= '0;
                        r_executed  <= r_exec;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                // store word is back, hand it out
                S_READ: begin
                    if (w_out_free) begin
                        r_kind      <= KIND_DISPATCH;
                        r_task      <= IDX_W'(r_rd_task);
                        r_out_data  <= OUT_DATA_W'(w_rdata);
                        r_executed  <= 1'b0;
                        r_last      <= 1'b0;
                        r_exec      <= 1'b1;
                        r_state     <= S_SCHED;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_task  = r_task;
    assign o_out_data  = r_out_data;
    assign o_executed  = r_executed;
    assign o_last      = r_last;

endmodule

`default_nettype wire

/* hw/rtl/ped_store.sv */
`default_nettype none

module ped_store import ped_pkg::*; #(
    parameter int DEPTH = NUM_TASKS_DEF * QUEUE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DW    = DATA_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // one write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/ped_pick.sv */
`default_nettype none

module ped_pick import ped_pkg::*; #(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int TIW       = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
    input  wire logic [NUM_TASKS-1:0]        i_mask,
    input  wire logic [NUM_TASKS*PRIO_W-1:0] i_prio,
    output logic                             o_found,
    output logic      [TIW-1:0]              o_sel
);

    // highest priority wins, the higher slot on a tie
    always_comb begin
        logic              found;
        logic [TIW-1:0]    sel;
        logic [PRIO_W-1:0] best;
        found = 1'b0;
        sel   = '0;
        best  = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            if (i_mask[t] && (!found || i_prio[t*PRIO_W +: PRIO_W] >= best)) begin
                found = 1'b1;
                best  = i_prio[t*PRIO_W +: PRIO_W];
                sel   = TIW'(t);
            end
        end
        o_found = found;
        o_sel   = sel;
    end

endmodule

`default_nettype wire
